[src/dcrq_pkg.sv]
// Package for the delayed command release queue.
// Holds the payload structs, op codes, controller states and control structs.
// Depends on nothing.
package dcrq_pkg;

   localparam int QueueDepth = 16;
   localparam int NumJoints  = 7;
   localparam int MaxRelease = 16;
   localparam int IdxWidth   = $clog2(QueueDepth);
   localparam int FillWidth  = $clog2(QueueDepth + 1);
   localparam int CntWidth   = $clog2(MaxRelease + 1);

   // Op codes of a request.
   localparam logic [1:0] OpLatch  = 2'd0;
   localparam logic [1:0] OpCommit = 2'd1;
   localparam logic [1:0] OpDelay  = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CsrWireless = 2'd0;
   localparam logic [1:0] CsrGravity  = 2'd1;

   // Joint index that names no joint.
   localparam logic [2:0] JointUnknown = 3'd7;

   typedef struct packed {
      logic [1:0]         op;
      logic [2:0]         joint;
      logic signed [31:0] torque;
      logic [47:0]        stamp;
      logic [47:0]        now;
      logic [31:0]        delay;
   } req_type;

   typedef struct packed {
      logic signed [31:0] torque_s0;
      logic signed [31:0] torque_s1;
      logic signed [31:0] torque_e0;
      logic signed [31:0] torque_e1;
      logic signed [31:0] torque_w0;
      logic signed [31:0] torque_w1;
      logic signed [31:0] torque_w2;
      logic [47:0]        entry_stamp;
      logic signed [47:0] motor_delay;
      logic               gravity_request;
      logic               last;
      logic [7:0]         dropped_total;
   } rsp_type;

   typedef logic [NumJoints-1:0][31:0] snap_type;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_DIRECT  = 5'b00010,
      ST_SCAN    = 5'b00100,
      ST_INSERT  = 5'b01000,
      ST_RELEASE = 5'b10000
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                 take_req;
      logic                 load_direct;
      logic                 drop;
      logic                 insert;
      logic                 pop;
      logic                 last;
      logic [FillWidth-1:0] pos;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic                 wireless;
      logic                 full;
      logic                 pos_le;
      logic                 front_due;
      logic                 next_due;
      logic                 out_free;
      logic [FillWidth-1:0] fill;
   } ctl_sts_type;

endpackage

[src/delayed_command_release_queue_core.sv]
// Top level of the delayed command release queue.
// Depends on dcrq_pkg, dcrq_ctrl and dcrq_datapath.
//
//   Channel  Ports                                Direction
//   req      req_valid, req_ready, req_payload    in  (latch, commit, set delay)
//   rsp      rsp_valid, rsp_ready, rsp_payload    out (0 to 16 snapshots per commit)
//   csr      csr_valid, csr_ready, csr_index,     in  (mode and gravity bits)
//            csr_wdata
//
// Latch and set-delay requests are taken in IDLE. A direct commit goes through
// DIRECT, which loads the output register once it is free. A delayed commit walks
// the queue one entry per cycle to find its slot, inserts in INSERT, then releases
// one due snapshot per cycle while the output register drains, until nothing else
// is due or MaxRelease snapshots are out. A commit on a full queue skips the walk.
// Reset is synchronous and empties the queue; a stalled rsp holds the release.
module delayed_command_release_queue_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dcrq_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dcrq_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic              csr_wdata
);

   dcrq_pkg::ctl_cmd_type cmd;
   dcrq_pkg::ctl_sts_type sts;

   assign csr_ready = 1'b1;

   dcrq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_payload.op),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dcrq_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

[src/dcrq_ctrl.sv]
// Controller state machine of the delayed command release queue.
// Depends on dcrq_pkg; drives the datapath through command and status structs.
module dcrq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_op,
   output logic                  req_ready,
   input  dcrq_pkg::ctl_sts_type sts,
   output dcrq_pkg::ctl_cmd_type cmd
);

   dcrq_pkg::state_type                   state_ff, state_in;
   logic [dcrq_pkg::FillWidth-1:0]        pos_ff, pos_in;
   logic [dcrq_pkg::CntWidth-1:0]         cnt_ff, cnt_in;
   logic                                  fire;
   logic                                  may_release;

   assign req_ready   = (state_ff == dcrq_pkg::ST_IDLE);
   assign fire        = req_valid && req_ready;
   assign may_release = sts.front_due &&
                        (cnt_ff < dcrq_pkg::CntWidth'(dcrq_pkg::MaxRelease));

   // Next state and commands.
   always_comb begin
      state_in        = state_ff;
      pos_in          = pos_ff;
      cnt_in          = cnt_ff;
      cmd             = '0;
      cmd.pos         = pos_ff;
      cmd.take_req    = fire;
      case (state_ff)
         dcrq_pkg::ST_IDLE: begin
            if (fire && req_op == dcrq_pkg::OpCommit) begin
               pos_in = '0;
               cnt_in = '0;
               if (!sts.wireless) begin
                  state_in = dcrq_pkg::ST_DIRECT;
               end else if (sts.full) begin
                  cmd.drop = 1'b1;
                  state_in = dcrq_pkg::ST_RELEASE;
               end else begin
                  state_in = dcrq_pkg::ST_SCAN;
               end
            end
         end
         dcrq_pkg::ST_DIRECT: begin
            if (sts.out_free) begin
               cmd.load_direct = 1'b1;
               state_in        = dcrq_pkg::ST_IDLE;
            end
         end
         dcrq_pkg::ST_SCAN: begin
            // Walk past every entry due no later than the new one.
            if (pos_ff < sts.fill && sts.pos_le) begin
               pos_in = pos_ff + 1'b1;
            end else begin
               state_in = dcrq_pkg::ST_INSERT;
            end
         end
         dcrq_pkg::ST_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = dcrq_pkg::ST_RELEASE;
         end
         dcrq_pkg::ST_RELEASE: begin
            if (may_release) begin
               if (sts.out_free) begin
                  cmd.pop  = 1'b1;
                  cmd.last = !sts.next_due ||
                     (cnt_ff == dcrq_pkg::CntWidth'(dcrq_pkg::MaxRelease - 1));
                  cnt_in   = cnt_ff + 1'b1;
               end
            end else begin
               state_in = dcrq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dcrq_pkg::ST_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dcrq_pkg::ST_IDLE;
         pos_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

[src/dcrq_datapath.sv]
// Datapath of the delayed command release queue: latches, sorted queue, output register.
// Depends on dcrq_pkg; controlled by dcrq_ctrl.
module dcrq_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  dcrq_pkg::req_type     req_payload,
   input  logic                  csr_valid,
   input  logic [1:0]            csr_index,
   input  logic                  csr_wdata,
   input  dcrq_pkg::ctl_cmd_type cmd,
   output dcrq_pkg::ctl_sts_type sts,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output dcrq_pkg::rsp_type     rsp_payload
);

   logic                             mode_ff, grav_ff;
   dcrq_pkg::snap_type               lat_ff;
   logic [31:0]                      cur_delay_ff;
   logic [7:0]                       drop_ff;
   logic [dcrq_pkg::FillWidth-1:0]   fill_ff;
   logic [47:0]                      stamp_ff, now_ff;
   logic [48:0]                      due_ff;
   logic [47:0]                      q_stamp_ff [dcrq_pkg::QueueDepth];
   logic [48:0]                      q_due_ff   [dcrq_pkg::QueueDepth];
   dcrq_pkg::snap_type               q_trq_ff   [dcrq_pkg::QueueDepth];
   dcrq_pkg::rsp_type                rsp_ff;
   logic                             rsp_valid_ff;
   logic                             out_free;
   logic [48:0]                      diff;
   logic [47:0]                      mdelay;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Status toward the controller.
   always_comb begin
      sts.wireless  = mode_ff;
      sts.full      = (fill_ff == dcrq_pkg::FillWidth'(dcrq_pkg::QueueDepth));
      sts.pos_le    = q_due_ff[cmd.pos[dcrq_pkg::IdxWidth-1:0]] <= due_ff;
      sts.front_due = (fill_ff != '0) && (q_due_ff[0] <= {1'b0, now_ff});
      sts.next_due  = (fill_ff > dcrq_pkg::FillWidth'(1)) &&
                      (q_due_ff[1] <= {1'b0, now_ff});
      sts.out_free  = out_free;
      sts.fill      = fill_ff;
   end

   // Motor delay, now minus stamp saturated to 48 signed bits.
   always_comb begin
      diff = {1'b0, now_ff} - {1'b0, stamp_ff};
      if (diff[48] == diff[47]) begin
         mdelay = diff[47:0];
      end else if (diff[48]) begin
         mdelay = {1'b1, 47'd0};
      end else begin
         mdelay = {1'b0, {47{1'b1}}};
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         grav_ff      <= 1'b0;
         lat_ff       <= '0;
         cur_delay_ff <= '0;
         drop_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_index == dcrq_pkg::CsrWireless) begin
            mode_ff <= csr_wdata;
         end
         if (csr_valid && csr_index == dcrq_pkg::CsrGravity) begin
            grav_ff <= csr_wdata;
         end
         if (cmd.take_req && req_payload.op == dcrq_pkg::OpLatch &&
             req_payload.joint != dcrq_pkg::JointUnknown) begin
            lat_ff[req_payload.joint] <= req_payload.torque;
         end
         if (cmd.take_req && req_payload.op == dcrq_pkg::OpDelay) begin
            cur_delay_ff <= req_payload.delay;
         end
         if (cmd.drop && drop_ff != 8'hFF) begin
            drop_ff <= drop_ff + 8'd1;
         end
         if (cmd.insert) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (cmd.pop) begin
            fill_ff <= fill_ff - 1'b1;
         end
         if (cmd.load_direct || cmd.pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Commit operands and the output register.
   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         stamp_ff <= req_payload.stamp;
         now_ff   <= req_payload.now;
         due_ff   <= {1'b0, req_payload.stamp} + {17'd0, cur_delay_ff};
      end
      if (cmd.load_direct) begin
         rsp_ff.torque_s0       <= lat_ff[0];
         rsp_ff.torque_s1       <= lat_ff[1];
         rsp_ff.torque_e0       <= lat_ff[2];
         rsp_ff.torque_e1       <= lat_ff[3];
         rsp_ff.torque_w0       <= lat_ff[4];
         rsp_ff.torque_w1       <= lat_ff[5];
         rsp_ff.torque_w2       <= lat_ff[6];
         rsp_ff.entry_stamp     <= stamp_ff;
         rsp_ff.motor_delay     <= mdelay;
         rsp_ff.gravity_request <= grav_ff;
         rsp_ff.last            <= 1'b1;
         rsp_ff.dropped_total   <= drop_ff;
      end else if (cmd.pop) begin
         rsp_ff.torque_s0       <= q_trq_ff[0][0];
         rsp_ff.torque_s1       <= q_trq_ff[0][1];
         rsp_ff.torque_e0       <= q_trq_ff[0][2];
         rsp_ff.torque_e1       <= q_trq_ff[0][3];
         rsp_ff.torque_w0       <= q_trq_ff[0][4];
         rsp_ff.torque_w1       <= q_trq_ff[0][5];
         rsp_ff.torque_w2       <= q_trq_ff[0][6];
         rsp_ff.entry_stamp     <= q_stamp_ff[0];
         rsp_ff.motor_delay     <= '0;
         rsp_ff.gravity_request <= grav_ff;
         rsp_ff.last            <= cmd.last;
         rsp_ff.dropped_total   <= drop_ff;
      end
   end

   // Queue entries: shift up on insertion, shift down on release.
   always_ff @(posedge clock) begin
      for (int i = 0; i < dcrq_pkg::QueueDepth; i++) begin
         if (cmd.insert) begin
            if (i == int'(cmd.pos)) begin
               q_stamp_ff[i] <= stamp_ff;
               q_due_ff[i]   <= due_ff;
               q_trq_ff[i]   <= lat_ff;
            end else if (i > int'(cmd.pos) && i > 0) begin
               q_stamp_ff[i] <= q_stamp_ff[(i > 0) ? i - 1 : 0];
               q_due_ff[i]   <= q_due_ff[(i > 0) ? i - 1 : 0];
               q_trq_ff[i]   <= q_trq_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (cmd.pop && i < dcrq_pkg::QueueDepth - 1) begin
            q_stamp_ff[i] <= q_stamp_ff[(i < dcrq_pkg::QueueDepth - 1) ? i + 1 : i];
            q_due_ff[i]   <= q_due_ff[(i < dcrq_pkg::QueueDepth - 1) ? i + 1 : i];
            q_trq_ff[i]   <= q_trq_ff[(i < dcrq_pkg::QueueDepth - 1) ? i + 1 : i];
         end
      end
   end

endmodule

[test/delayed_command_release_queue_core_tb.sv]
// Testbench for delayed_command_release_queue_core: drives latch, commit and
// set-delay requests, predicts every released snapshot and checks each one.
// Depends on dcrq_pkg and the core RTL.
`timescale 1ns / 1ps

module delayed_command_release_queue_core_tb;

   localparam int CycleLimit = 400000;

   // Op code that the block ignores.
   localparam logic [1:0] OpSpare = 2'd3;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   dcrq_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_ready;
   dcrq_pkg::rsp_type rsp_payload;
   logic              csr_valid;
   logic              csr_ready;
   logic [1:0]        csr_index;
   logic              csr_wdata;

   delayed_command_release_queue_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Shadow copy of the block's state.
   logic               mode_wireless;
   logic               mode_gravity;
   logic [31:0]        joint_torque [dcrq_pkg::NumJoints];
   dcrq_pkg::snap_type pending_snap [$];
   logic [47:0]        pending_stamp [$];
   logic [48:0]        pending_due [$];
   logic [31:0]        delay_now;
   logic [7:0]         drops;

   dcrq_pkg::rsp_type expected_snapshots [$];
   int      errors;
   int      cycles;
   int      stall_hold;
   bit      stall_random;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Cycle counter and timeout.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic dcrq_pkg::rsp_type make_snapshot(dcrq_pkg::snap_type s,
                                                       logic [47:0] st,
                                                       logic [47:0] md);
      dcrq_pkg::rsp_type r;
      r.torque_s0 = s[0]; r.torque_s1 = s[1]; r.torque_e0 = s[2];
      r.torque_e1 = s[3]; r.torque_w0 = s[4]; r.torque_w1 = s[5];
      r.torque_w2 = s[6];
      r.entry_stamp = st;
      r.motor_delay = md;
      r.gravity_request = mode_gravity;
      r.last = 1'b0;
      r.dropped_total = drops;
      return r;
   endfunction

   // Update the shadow state for one accepted request and queue its snapshots.
   task automatic predict_release(dcrq_pkg::req_type q);
      dcrq_pkg::snap_type s;
      logic signed [49:0] d;
      logic [48:0]        due;
      int                 pos;
      int                 n;
      dcrq_pkg::rsp_type  r;
      for (int j = 0; j < dcrq_pkg::NumJoints; j++) s[j] = joint_torque[j];
      if (q.op == dcrq_pkg::OpLatch) begin
         if (q.joint != dcrq_pkg::JointUnknown) joint_torque[q.joint] = q.torque;
      end else if (q.op == dcrq_pkg::OpDelay) begin
         delay_now = q.delay;
      end else if (q.op == dcrq_pkg::OpCommit) begin
         if (!mode_wireless) begin
            d = $signed({2'b00, q.now}) - $signed({2'b00, q.stamp});
            if (d > 50'sh7FFFFFFFFFFF) d = 50'sh7FFFFFFFFFFF;
            if (d < -50'sh800000000000) d = -50'sh800000000000;
            r = make_snapshot(s, q.stamp, d[47:0]);
            r.last = 1'b1;
            expected_snapshots.insert(expected_snapshots.size(), r);
         end else begin
            if (pending_due.size() >= dcrq_pkg::QueueDepth) begin
               if (drops != 8'hFF) drops++;
            end else begin
               due = {1'b0, q.stamp} + {17'd0, delay_now};
               pos = 0;
               while (pos < pending_due.size() && pending_due[pos] <= due) pos++;
               pending_due.insert(pos, due);
               pending_stamp.insert(pos, q.stamp);
               pending_snap.insert(pos, s);
            end
            n = 0;
            while (pending_due.size() > 0 && n < dcrq_pkg::MaxRelease &&
                   pending_due[0] <= {1'b0, q.now}) begin
               r = make_snapshot(pending_snap[0], pending_stamp[0], 48'd0);
               expected_snapshots.insert(expected_snapshots.size(), r);
               void'(pending_due.pop_front());
               void'(pending_stamp.pop_front());
               void'(pending_snap.pop_front());
               n++;
            end
            if (n > 0) expected_snapshots[$].last = 1'b1;
         end
      end
   endtask

   // Result checker and receiver stall pattern.
   always @(posedge clock) begin
      dcrq_pkg::rsp_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_snapshots.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_payload);
               errors++;
            end else begin
               e = expected_snapshots.pop_front();
               if (rsp_payload !== e) begin
                  $display("%0t: mismatch expected %h actual %h", $time, e,
                           rsp_payload);
                  errors++;
               end
            end
         end
         if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
            rsp_ready <= 1'b0;
         end else if (stall_random) begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Send one request, with a random gap before it when bursts are on.
   // Valid stays high after acceptance until the next request or an idle task.
   task automatic send_request(dcrq_pkg::req_type q, bit gaps);
      if (gaps && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_release(q);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_snapshots.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == dcrq_pkg::CsrWireless) mode_wireless = val;
      else if (idx == dcrq_pkg::CsrGravity) mode_gravity = val;
      @(posedge clock);
   endtask

   function automatic dcrq_pkg::req_type rand_request(logic [1:0] op);
      dcrq_pkg::req_type q;
      q.op = op;
      q.joint = 3'($urandom_range(0, 7));
      q.torque = $urandom;
      q.stamp = 48'({$urandom, $urandom});
      q.now = 48'({$urandom, $urandom});
      q.delay = $urandom;
      return q;
   endfunction

   // Extremes of joint fields, unknown joint, unused op, direct commits.
   task automatic test_direct();
      dcrq_pkg::req_type q;
      write_csr(dcrq_pkg::CsrWireless, 1'b0);
      write_csr(dcrq_pkg::CsrGravity, 1'b1);
      q = rand_request(dcrq_pkg::OpLatch); q.joint = 3'd0; q.torque = 32'sh7FFFFFFF;
      send_request(q, 0);
      q.joint = 3'd6; q.torque = 32'sh80000000; send_request(q, 0);
      q.joint = dcrq_pkg::JointUnknown; q.torque = 32'sh12345678; send_request(q, 0);
      q = rand_request(OpSpare); send_request(q, 0);
      q = rand_request(dcrq_pkg::OpCommit); q.stamp = 48'd0; q.now = 48'hFFFFFFFFFFFF;
      send_request(q, 0);
      q.stamp = 48'hFFFFFFFFFFFF; q.now = 48'd0; send_request(q, 0);
      q.stamp = 48'd1000; q.now = 48'd1500; send_request(q, 0);
      wait_drained();
      write_csr(dcrq_pkg::CsrGravity, 1'b0);
   endtask

   // Delayed mode: ties, nothing due, queue full with drops, mode change.
   task automatic test_delayed();
      dcrq_pkg::req_type q;
      write_csr(dcrq_pkg::CsrWireless, 1'b1);
      q = rand_request(dcrq_pkg::OpDelay); q.delay = 32'hFFFFFFFF; send_request(q, 0);
      q = rand_request(dcrq_pkg::OpCommit); q.stamp = 48'hFFFFFFFFFFFF; q.now = 48'd0;
      send_request(q, 0);
      q = rand_request(dcrq_pkg::OpDelay); q.delay = 32'd10; send_request(q, 0);
      for (int i = 0; i < 18; i++) begin
         q = rand_request(dcrq_pkg::OpLatch); q.joint = 3'(i % 7); send_request(q, 0);
         q = rand_request(dcrq_pkg::OpCommit); q.stamp = 48'(100 + i % 3);
         q.now = 48'd5;
         send_request(q, 0);
      end
      wait_drained();
      write_csr(dcrq_pkg::CsrWireless, 1'b0);
      q = rand_request(dcrq_pkg::OpCommit); send_request(q, 0);
      wait_drained();
      write_csr(dcrq_pkg::CsrWireless, 1'b1);
      q = rand_request(dcrq_pkg::OpCommit); q.stamp = 48'd0; q.now = 48'hFFFFFFFFFFFF;
      send_request(q, 0);
      wait_drained();
   endtask

   // Random frames of latches followed by commits on a moving clock.
   task automatic test_random(logic wireless, int count);
      dcrq_pkg::req_type q;
      logic [47:0] clk_us;
      int r;
      write_csr(dcrq_pkg::CsrWireless, wireless);
      write_csr(dcrq_pkg::CsrGravity, 1'($urandom_range(0, 1)));
      clk_us = 48'($urandom_range(0, 1000));
      stall_random = 1;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 9);
         if (r < 5) begin
            q = rand_request(dcrq_pkg::OpLatch);
            send_request(q, 1);
         end else if (r == 5) begin
            q = rand_request(dcrq_pkg::OpDelay);
            q.delay = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 400);
            send_request(q, 1);
         end else if (r == 6 && $urandom_range(0, 3) == 0) begin
            q = rand_request(OpSpare);
            send_request(q, 1);
         end else begin
            q = rand_request(dcrq_pkg::OpCommit);
            clk_us = clk_us + 48'($urandom_range(0, 150));
            q.now = ($urandom_range(0, 15) == 0) ? q.now : clk_us;
            if ($urandom_range(0, 15) != 0)
               q.stamp = clk_us - 48'($urandom_range(0, 100));
            send_request(q, 1);
         end
      end
      wait_drained();
      stall_random = 0;
   endtask

   // Long receiver hold-off while direct commits keep coming.
   task automatic test_backpressure();
      dcrq_pkg::req_type q;
      write_csr(dcrq_pkg::CsrWireless, 1'b0);
      stall_hold = 300;
      for (int i = 0; i < 12; i++) begin
         q = rand_request(dcrq_pkg::OpCommit);
         send_request(q, 0);
      end
      wait_drained();
   endtask

   initial begin
      errors = 0;
      cycles = 0;
      stall_hold = 0;
      stall_random = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_valid = 1'b0;
      csr_index = dcrq_pkg::CsrWireless;
      csr_wdata = 1'b0;
      mode_wireless = 1'b0;
      mode_gravity = 1'b0;
      delay_now = '0;
      drops = '0;
      for (int j = 0; j < dcrq_pkg::NumJoints; j++) joint_torque[j] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_direct();
      test_delayed();
      test_backpressure();
      test_random(1'b1, 50);
      test_random(1'b0, 20);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
